FILE: design/rifma_pkg.sv
// Shared types and constants for the radar I/Q frame moving-average block.
// No dependencies; compiled first.
package rifma_pkg;

    localparam int DATA_W      = 8;
    localparam int RAW_W       = 16;
    localparam int MAG_W       = 17;
    localparam int SUM_OUT_W   = 20;
    localparam int AVG_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam int WINDOW_SIZE_DEF = 16;
    localparam int FRAME_BYTES_DEF = 14;

    localparam int POS_I_HIGH = 7;
    localparam int POS_I_LOW  = 8;
    localparam int POS_Q_HIGH = 9;
    localparam int POS_Q_LOW  = 10;

    localparam logic [DATA_W-1:0] START_DELIM_RST = 8'd104;
    localparam logic [DATA_W-1:0] END_DELIM_RST   = 8'h16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_DELIM = 1'b0,
        CFG_END_DELIM   = 1'b1
    } t_cfg_idx;

endpackage

FILE: design/rifma_rx_if.sv
// Byte input channel: valid/ready handshake carrying one received byte.
// Depends on rifma_pkg.
interface rifma_rx_if
    import rifma_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: design/rifma_res_if.sv
// Result channel: valid/ready handshake carrying one filtered I/Q sample.
// Depends on rifma_pkg.
interface rifma_res_if
    import rifma_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [RAW_W-1:0]     i_raw;
    logic signed [RAW_W-1:0]     q_raw;
    logic        [SUM_OUT_W-1:0] i_window_sum;
    logic        [SUM_OUT_W-1:0] q_window_sum;
    logic        [AVG_W-1:0]     i_average;
    logic        [AVG_W-1:0]     q_average;
    logic                        window_full;
    logic                        frame_overrun;

    modport source (
        output valid, output i_raw, output q_raw, output i_window_sum,
        output q_window_sum, output i_average, output q_average,
        output window_full, output frame_overrun, input ready
    );
    modport sink (
        input valid, input i_raw, input q_raw, input i_window_sum,
        input q_window_sum, input i_average, input q_average,
        input window_full, input frame_overrun, output ready
    );
endinterface

FILE: design/radar_iq_frame_moving_average.sv
// Top level of the radar I/Q frame moving-average block.
// Depends on rifma_pkg, rifma_rx_if and rifma_res_if.
//
// Usage:
//   i_rx carries one serial byte per transfer. A byte equal to the start
//   delimiter restarts the frame position; bytes at positions 7..10 are kept
//   as I high/low and Q high/low. A byte equal to the end delimiter releases
//   one sample on o_res: raw I and Q, sums of |I| and |Q| over the last
//   WINDOW_SIZE samples, their truncated averages and the window-full and
//   frame-overrun flags. Other bytes produce no result.
//   The config port (i_cfg_we, i_cfg_idx, i_cfg_wdata) sets the start and end
//   delimiters; write it only while the block is idle.
// Timing:
//   One byte per cycle is accepted until a stalled o_res fills the pipeline. The
//   frame and window update is registered in the first stage; the reciprocal
//   multiply that forms the averages is registered in the second, which drives o_res.
//   The window is a WINDOW_SIZE-entry memory read one entry ahead of use.
// Reset and stall:
//   Reset clears frame position, sums, fill count and delimiters to defaults;
//   window contents are read only after written. When o_res stalls, the
//   two-stage pipeline fills and i_rx.ready drops until a result is taken.
module radar_iq_frame_moving_average
    import rifma_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    rifma_rx_if.sink             i_rx,
    rifma_res_if.source          o_res
);

    localparam int PTR_W   = $clog2(WINDOW_SIZE);
    localparam int FILL_W  = $clog2(WINDOW_SIZE + 1);
    localparam int POS_W   = $clog2(FRAME_BYTES + 1);
    localparam int SUM_W   = $clog2(WINDOW_SIZE * 32768 + 1);
    localparam int SHIFT_K = SUM_W + $clog2(WINDOW_SIZE);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT_K) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE);

    logic [DATA_W-1:0]    r_start_delim;
    logic [DATA_W-1:0]    r_end_delim;

    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_ovr, n_ovr;
    logic [DATA_W-1:0]    r_capt [4];
    logic [DATA_W-1:0]    n_capt [4];
    logic [PTR_W-1:0]     r_ptr, n_ptr;
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic [SUM_W-1:0]     r_isum, n_isum;
    logic [SUM_W-1:0]     r_qsum, n_qsum;
    logic [2*MAG_W-1:0]   r_win [WINDOW_SIZE];
    logic [2*MAG_W-1:0]   r_old;

    logic                 r_v1;
    logic [RAW_W-1:0]     r_iraw1, r_qraw1;
    logic [SUM_W-1:0]     r_isum1, r_qsum1;
    logic                 r_full1, r_ovr1;

    logic                 r_v2;
    logic [RAW_W-1:0]     r_o_iraw, r_o_qraw;
    logic [SUM_OUT_W-1:0] r_o_isum, r_o_qsum;
    logic [AVG_W-1:0]     r_o_iavg, r_o_qavg;
    logic                 r_o_full, r_o_ovr;

    logic                 adv1, adv2, acc, is_start, is_end, sample;
    logic                 in_frame, was_full;
    logic [POS_W-1:0]     pos0;
    logic [RAW_W-1:0]     i_bits, q_bits;
    logic [MAG_W-1:0]     i_mag, q_mag, old_i, old_q;
    logic [PROD_W-1:0]    i_prod, q_prod;
    logic [PROD_W-1:0]    i_quot, q_quot;

    assign adv2       = !r_v2 || o_res.ready;
    assign adv1       = !r_v1 || adv2;
    assign i_rx.ready = adv1;
    assign acc        = i_rx.valid && adv1;
    assign is_start   = i_rx.rx_byte == r_start_delim;
    assign is_end     = i_rx.rx_byte == r_end_delim;
    assign sample     = acc && is_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delim <= START_DELIM_RST;
            r_end_delim   <= END_DELIM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START_DELIM: r_start_delim <= i_cfg_wdata;
                CFG_END_DELIM:   r_end_delim   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        pos0     = is_start ? '0 : r_pos;
        in_frame = pos0 < POS_W'(FRAME_BYTES);
        n_pos    = pos0;
        n_ovr    = is_start ? 1'b0 : r_ovr;
        n_capt   = r_capt;
        if (in_frame) begin
            if (pos0 >= POS_W'(POS_I_HIGH) && pos0 <= POS_W'(POS_Q_LOW)) begin
                n_capt[2'(pos0 - POS_W'(POS_I_HIGH))] = i_rx.rx_byte;
            end
            n_pos = pos0 + POS_W'(1);
        end else begin
            n_ovr = 1'b1;
        end
    end

    assign i_bits = {n_capt[0], n_capt[1]};
    assign q_bits = {n_capt[2], n_capt[3]};
    assign i_mag  = i_bits[RAW_W-1] ? MAG_W'(17'h10000 - {1'b0, i_bits}) : {1'b0, i_bits};
    assign q_mag  = q_bits[RAW_W-1] ? MAG_W'(17'h10000 - {1'b0, q_bits}) : {1'b0, q_bits};
    assign old_i  = r_old[2*MAG_W-1:MAG_W];
    assign old_q  = r_old[MAG_W-1:0];

    always_comb begin
        was_full = r_fill == FILL_W'(WINDOW_SIZE);
        n_ptr    = r_ptr;
        n_fill   = r_fill;
        n_isum   = r_isum;
        n_qsum   = r_qsum;
        if (sample) begin
            n_ptr  = (r_ptr == PTR_W'(WINDOW_SIZE - 1)) ? '0 : r_ptr + PTR_W'(1);
            n_fill = was_full ? r_fill : r_fill + FILL_W'(1);
            n_isum = r_isum - (was_full ? SUM_W'(old_i) : '0) + SUM_W'(i_mag);
            n_qsum = r_qsum - (was_full ? SUM_W'(old_q) : '0) + SUM_W'(q_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_ovr  <= 1'b0;
            r_capt <= '{default: '0};
            r_ptr  <= '0;
            r_fill <= '0;
            r_isum <= '0;
            r_qsum <= '0;
        end else if (acc) begin
            r_pos  <= n_pos;
            r_ovr  <= n_ovr;
            r_capt <= n_capt;
            r_ptr  <= n_ptr;
            r_fill <= n_fill;
            r_isum <= n_isum;
            r_qsum <= n_qsum;
        end
    end

    // Read one entry ahead so the oldest sample is registered when needed
    always_ff @(posedge i_clk) begin
        if (sample) begin
            r_win[r_ptr] <= {i_mag, q_mag};
        end
        r_old <= r_win[acc ? n_ptr : r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv1) begin
            r_v1 <= sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sample) begin
            r_iraw1 <= i_bits;
            r_qraw1 <= q_bits;
            r_isum1 <= n_isum;
            r_qsum1 <= n_qsum;
            r_full1 <= n_fill == FILL_W'(WINDOW_SIZE);
            r_ovr1  <= n_ovr;
        end
    end

    assign i_prod = PROD_W'(r_isum1) * PROD_W'(RECIP[RECIP_W-1:0]);
    assign q_prod = PROD_W'(r_qsum1) * PROD_W'(RECIP[RECIP_W-1:0]);
    assign i_quot = i_prod >> SHIFT_K;
    assign q_quot = q_prod >> SHIFT_K;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_o_iraw <= r_iraw1;
            r_o_qraw <= r_qraw1;
            r_o_isum <= SUM_OUT_W'(r_isum1);
            r_o_qsum <= SUM_OUT_W'(r_qsum1);
            r_o_iavg <= r_full1 ? i_quot[AVG_W-1:0] : '0;
            r_o_qavg <= r_full1 ? q_quot[AVG_W-1:0] : '0;
            r_o_full <= r_full1;
            r_o_ovr  <= r_ovr1;
        end
    end

    assign o_res.valid         = r_v2;
    assign o_res.i_raw         = r_o_iraw;
    assign o_res.q_raw         = r_o_qraw;
    assign o_res.i_window_sum  = r_o_isum;
    assign o_res.q_window_sum  = r_o_qsum;
    assign o_res.i_average     = r_o_iavg;
    assign o_res.q_average     = r_o_qavg;
    assign o_res.window_full   = r_o_full;
    assign o_res.frame_overrun = r_o_ovr;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_SIZE))
        else $error("fill count beyond window size");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(FRAME_BYTES))
        else $error("frame position beyond frame length");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr < PTR_W'(WINDOW_SIZE) || WINDOW_SIZE == (1 << PTR_W))
        else $error("window pointer out of range");

    a_end_to_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sample |=> r_v1)
        else $error("end delimiter transfer lost");

    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !r_o_full) |-> (r_o_iavg == '0 && r_o_qavg == '0))
        else $error("average reported before window full");

endmodule

FILE: test/tb_radar_iq_frame_moving_average.sv
`timescale 1ns / 100ps
// Testbench for radar_iq_frame_moving_average: byte stream in, filtered I/Q samples out.
// Depends on rifma_pkg, rifma_rx_if, rifma_res_if and the block itself.
// A local frame and window predictor queues expected samples.
module tb_radar_iq_frame_moving_average;
    import rifma_pkg::*;

    localparam int WIN         = WINDOW_SIZE_DEF;
    localparam int FRAME_LEN   = FRAME_BYTES_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [RAW_W-1:0] i_raw;
        logic signed [RAW_W-1:0] q_raw;
        logic [SUM_OUT_W-1:0]    i_window_sum;
        logic [SUM_OUT_W-1:0]    q_window_sum;
        logic [AVG_W-1:0]        i_average;
        logic [AVG_W-1:0]        q_average;
        logic                    window_full;
        logic                    frame_overrun;
    } t_iq_sample;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_wdata;

    rifma_rx_if  byte_ch ();
    rifma_res_if sample_ch ();

    radar_iq_frame_moving_average i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (byte_ch),
        .o_res       (sample_ch)
    );

    // Predictor state
    logic [DATA_W-1:0] start_delim_m;
    logic [DATA_W-1:0] end_delim_m;
    int unsigned       frame_pos;
    logic              overrun_m;
    logic [7:0]        cap_bytes [4];
    int unsigned       i_win [WIN];
    int unsigned       q_win [WIN];
    int unsigned       win_ptr;
    int unsigned       fill_cnt;
    int unsigned       i_acc;
    int unsigned       q_acc;

    t_iq_sample expected_samples[$];
    int         error_count = 0;
    int         bytes_sent = 0;
    int         cycle_count = 0;
    bit         src_quiet = 1'b0;
    bit         snk_quiet = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** radar_iq_frame_moving_average: FAILED **");
            $finish;
        end
    end

    function automatic void reset_iq_filter();
        start_delim_m = START_DELIM_RST;
        end_delim_m   = END_DELIM_RST;
        frame_pos     = 0;
        overrun_m     = 1'b0;
        for (int k = 0; k < 4; k++) cap_bytes[k] = 8'h00;
        win_ptr  = 0;
        fill_cnt = 0;
        i_acc    = 0;
        q_acc    = 0;
    endfunction

    function automatic bit advance_iq_filter(input logic [7:0] b, output t_iq_sample s);
        logic [15:0] i_bits;
        logic [15:0] q_bits;
        int unsigned i_mag;
        int unsigned q_mag;
        bit          full;
        if (b == start_delim_m) begin
            frame_pos = 0;
            overrun_m = 1'b0;
        end
        if (frame_pos < FRAME_LEN) begin
            if (frame_pos >= POS_I_HIGH && frame_pos <= POS_Q_LOW)
                cap_bytes[frame_pos - POS_I_HIGH] = b;
            frame_pos++;
        end else begin
            overrun_m = 1'b1;
        end
        if (b != end_delim_m)
            return 1'b0;
        i_bits = {cap_bytes[0], cap_bytes[1]};
        q_bits = {cap_bytes[2], cap_bytes[3]};
        i_mag  = i_bits[15] ? 32'd65536 - i_bits : i_bits;
        q_mag  = q_bits[15] ? 32'd65536 - q_bits : q_bits;
        if (fill_cnt >= WIN) begin
            i_acc -= i_win[win_ptr];
            q_acc -= q_win[win_ptr];
        end else begin
            fill_cnt++;
        end
        i_acc += i_mag;
        q_acc += q_mag;
        i_win[win_ptr] = i_mag;
        q_win[win_ptr] = q_mag;
        win_ptr = (win_ptr + 1) % WIN;
        full = (fill_cnt >= WIN);
        s.i_raw         = i_bits;
        s.q_raw         = q_bits;
        s.i_window_sum  = i_acc[SUM_OUT_W-1:0];
        s.q_window_sum  = q_acc[SUM_OUT_W-1:0];
        s.i_average     = full ? AVG_W'(i_acc / WIN) : '0;
        s.q_average     = full ? AVG_W'(q_acc / WIN) : '0;
        s.window_full   = full;
        s.frame_overrun = overrun_m;
        return 1'b1;
    endfunction

    function automatic bit is_delim(input logic [7:0] b);
        return (b == start_delim_m) || (b == end_delim_m);
    endfunction

    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (is_delim(b));
        return b;
    endfunction

    function automatic logic [15:0] pick_iq_word();
        logic [15:0] w;
        do begin
            case ($urandom_range(0, 7))
                0:       w = 16'h8000;
                1:       w = 16'h7FFF;
                2:       w = 16'hFFFF;
                3:       w = 16'h0000;
                4:       w = 16'h8001;
                default: w = 16'($urandom);
            endcase
        end while (is_delim(w[15:8]) || is_delim(w[7:0]));
        return w;
    endfunction

    // Hold valid high across back-to-back transfers; lower it only for a gap.
    task automatic send_byte(input logic [7:0] b);
        int         gap;
        t_iq_sample s;
        gap = src_quiet ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 23) == 0) src_quiet = !src_quiet;
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        if (advance_iq_filter(b, s)) expected_samples.push_back(s);
        bytes_sent++;
    endtask

    task automatic send_sample_frame(input logic [15:0] iw, input logic [15:0] qw,
                                     input int tail);
        send_byte(start_delim_m);
        repeat (POS_I_HIGH - 1) send_byte(filler_byte());
        send_byte(iw[15:8]);
        send_byte(iw[7:0]);
        send_byte(qw[15:8]);
        send_byte(qw[7:0]);
        repeat (tail) send_byte(filler_byte());
        send_byte(end_delim_m);
    endtask

    task automatic send_random_frame();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3, 4, 5, 6: begin
                send_sample_frame(pick_iq_word(), pick_iq_word(), $urandom_range(0, 2));
            end
            7: begin
                send_sample_frame(pick_iq_word(), pick_iq_word(), $urandom_range(3, 6));
            end
            8: begin
                send_byte(start_delim_m);
                repeat ($urandom_range(0, 9)) send_byte(filler_byte());
                send_byte(end_delim_m);
            end
            default: begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        endcase
    endtask

    // Drain outstanding samples, then let the pipeline settle.
    task automatic drain_pipeline();
        byte_ch.valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_delims(input logic [7:0] sd, input logic [7:0] ed);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_START_DELIM;
        i_cfg_wdata <= sd;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_END_DELIM;
        i_cfg_wdata <= ed;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        start_delim_m = sd;
        end_delim_m   = ed;
    endtask

    task automatic check_sample(input t_iq_sample got);
        t_iq_sample want;
        if (expected_samples.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("unexpected sample: i_raw=%0d q_raw=%0d", got.i_raw, got.q_raw);
        end else begin
            want = expected_samples.pop_front();
            if (got !== want) begin
                error_count++;
                if (error_count <= 10) begin
                    $display({"mismatch exp: i=%0d q=%0d isum=%0d qsum=%0d ",
                              "iavg=%0d qavg=%0d f=%0b o=%0b"},
                             want.i_raw, want.q_raw, want.i_window_sum, want.q_window_sum,
                             want.i_average, want.q_average, want.window_full,
                             want.frame_overrun);
                    $display({"         got: i=%0d q=%0d isum=%0d qsum=%0d ",
                              "iavg=%0d qavg=%0d f=%0b o=%0b"},
                             got.i_raw, got.q_raw, got.i_window_sum, got.q_window_sum,
                             got.i_average, got.q_average, got.window_full,
                             got.frame_overrun);
                end
            end
        end
    endtask

    initial begin
        int         gap;
        t_iq_sample got;
        sample_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = snk_quiet ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 23) == 0) snk_quiet = !snk_quiet;
            if (gap > 0) begin
                sample_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            sample_ch.ready <= 1'b1;
            do @(posedge i_clk); while (sample_ch.valid !== 1'b1);
            got.i_raw         = sample_ch.i_raw;
            got.q_raw         = sample_ch.q_raw;
            got.i_window_sum  = sample_ch.i_window_sum;
            got.q_window_sum  = sample_ch.q_window_sum;
            got.i_average     = sample_ch.i_average;
            got.q_average     = sample_ch.q_average;
            got.window_full   = sample_ch.window_full;
            got.frame_overrun = sample_ch.frame_overrun;
            check_sample(got);
        end
    end

    task automatic test_extreme_values();
        send_byte(start_delim_m);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h01);
        send_byte(8'hFE);
        send_byte(8'h80);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'hFF);
        send_byte(end_delim_m);
    endtask

    // Position climbs to the frame length and then holds; past the end, bytes are not captured and flag overrun.
    task automatic test_frame_tail();
        send_byte(end_delim_m);
        send_byte(8'h33);
        send_byte(8'h44);
        send_byte(end_delim_m);
    endtask

    task automatic test_delimiter_in_sample();
        send_byte(start_delim_m);
        repeat (POS_I_HIGH - 1) send_byte(filler_byte());
        send_byte(end_delim_m);
    endtask

    task automatic test_equal_delimiters();
        drain_pipeline();
        set_delims(8'hFF, 8'hFF);
        send_byte(8'hFF);
        send_byte(8'h12);
        send_byte(8'hFF);
    endtask

    task automatic test_random_traffic(input logic [7:0] sd, input logic [7:0] ed,
                                       input int n_bytes);
        int target;
        drain_pipeline();
        set_delims(sd, ed);
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) send_random_frame();
    endtask

    task automatic test_full_scale_window();
        repeat (WIN + 2) send_sample_frame(16'h8000, 16'h8000, $urandom_range(0, 2));
    endtask

    initial begin
        reset_iq_filter();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_START_DELIM;
        i_cfg_wdata     <= '0;
        byte_ch.valid   <= 1'b0;
        byte_ch.rx_byte <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_values();
        test_frame_tail();
        test_delimiter_in_sample();
        test_equal_delimiters();
        test_random_traffic(START_DELIM_RST, END_DELIM_RST, 100);
        test_full_scale_window();
        test_random_traffic(8'h00, 8'hFF, 100);
        test_random_traffic(8'hFF, 8'h00, 100);
        test_random_traffic(8'($urandom), 8'($urandom), 80);

        drain_pipeline();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && expected_samples.size() == 0) begin
            $display("** radar_iq_frame_moving_average: PASSED **");
        end else begin
            $display("** radar_iq_frame_moving_average: FAILED **");
        end
        $finish;
    end
endmodule
